>>> rtl/core/multilevel_ready_queue_assert.svh
// Assertion macros for the multilevel ready queue.
`ifndef MULTILEVEL_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_READY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define MRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRQ_ASSERT(lbl, prop, msg)
`define MRQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/core/mrq_pkg.sv
// Constants and codes shared by the multilevel ready queue.
package mrq_pkg;

  localparam int LEVELS      = 4;
  localparam int QUEUE_DEPTH = 16;

  localparam int KIND_W   = 2;
  localparam int LEVEL_W  = 2;
  localparam int PID_W    = 16;
  localparam int TIME_W   = 16;
  localparam int STATUS_W = 2;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);
  localparam int ENTRY_W = PID_W + TIME_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ       = 2'd0,
    KIND_DEQ       = 2'd1,
    KIND_DEQ_FIRST = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

endpackage

>>> rtl/core/multilevel_ready_queue.sv
// Multilevel ready queue: per-level ring-buffer FIFOs with a priority dequeue.
//
// A bank of LEVELS bounded FIFOs, one per priority level (level 0 most urgent),
// each QUEUE_DEPTH entries of process id and time. A beat on the input channel
// enqueues at a level, dequeues the head of a level, or dequeues the head of the
// lowest-numbered non-empty level; every input beat yields exactly one output
// beat with a status, the removed entry and its level (zeros when nothing is
// removed), and a flag that is set when all levels are empty afterwards. An
// enqueue to a full level is dropped and reported full; a dequeue from an empty
// level reports empty; kind 3 does nothing and reports ok. Timing: a beat is
// registered at the input, then the pointer update, priority encode and entry
// store access take place and the result is registered; one beat is taken
// every cycle while the output is not stalled. The rate is set by the pointer
// and fill-count update, which every beat needs before the next. The entry
// store is a 64 x 32 memory with one write and one registered read per cycle;
// it needs no clearing after reset, since the read data of an entry is only
// used after the entry has been written.
module multilevel_ready_queue
  import mrq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [LEVEL_W-1:0]         level,
  input  logic [PID_W-1:0]           process_id,
  input  logic signed [TIME_W-1:0]   time_value,
  // output channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [PID_W-1:0]           out_process_id,
  output logic signed [TIME_W-1:0]   out_time_value,
  output logic [LEVEL_W-1:0]         out_level,
  output logic                       all_empty
);

`include "multilevel_ready_queue_assert.svh"

  // Input register
  logic                     s1_valid;
  logic [KIND_W-1:0]        s1_kind;
  logic [LEVEL_W-1:0]       s1_level;
  logic [PID_W-1:0]         s1_pid;
  logic [TIME_W-1:0]        s1_time;

  // Queue state
  logic [PTR_W-1:0] head_index [LEVELS];
  logic [PTR_W-1:0] tail_index [LEVELS];
  logic [CNT_W-1:0] fill_count [LEVELS];

  logic [PTR_W-1:0] head_index_next [LEVELS];
  logic [PTR_W-1:0] tail_index_next [LEVELS];
  logic [CNT_W-1:0] fill_count_next [LEVELS];

  // Entry store: no reset, every slot whose read data is used has been written before
  logic [ENTRY_W-1:0] entry_store [LEVELS*QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  // Result register
  logic                removed;
  logic [STATUS_W-1:0] status_reg;
  logic [LEVEL_W-1:0]  level_reg;
  logic                all_empty_reg;

  // Decision logic
  logic                advance;
  logic                do_write;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic                removed_next;
  logic [STATUS_W-1:0] status_next;
  logic [LEVEL_W-1:0]  level_next;
  logic                all_empty_next;
  logic                level_ok;
  logic                first_found;
  logic [LEVEL_W-1:0]  first_level;
  logic [LEVEL_W-1:0]  pop_level;
  logic                pop_en;

  // The result register moves on when it is empty or its beat is taken;
  // the input register only loads when the result register moves on
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
    if (int'(ptr) == QUEUE_DEPTH - 1) begin
      return '0;
    end
    return ptr + PTR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LEVEL_W-1:0] lvl,
                                                  input logic [PTR_W-1:0] ptr);
    return ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
  endfunction

  always_comb begin
    level_ok = int'(s1_level) < LEVELS;

    // Priority encode: lowest-numbered non-empty level wins
    first_found = 1'b0;
    first_level = '0;
    for (int q = LEVELS - 1; q >= 0; q--) begin
      if (fill_count[q] != '0) begin
        first_found = 1'b1;
        first_level = LEVEL_W'(q);
      end
    end

    for (int q = 0; q < LEVELS; q++) begin
      head_index_next[q] = head_index[q];
      tail_index_next[q] = tail_index[q];
      fill_count_next[q] = fill_count[q];
    end

    do_write     = 1'b0;
    pop_en       = 1'b0;
    pop_level    = s1_level;
    removed_next = 1'b0;
    status_next  = STAT_OK;
    wr_addr      = slot_addr(s1_level, tail_index[s1_level]);

    case (s1_kind)
      KIND_ENQ: begin
        if (!level_ok || int'(fill_count[s1_level]) >= QUEUE_DEPTH) begin
          status_next = STAT_FULL;
        end else begin
          do_write = 1'b1;
          tail_index_next[s1_level] = ring_next(tail_index[s1_level]);
          fill_count_next[s1_level] = fill_count[s1_level] + CNT_W'(1);
        end
      end
      KIND_DEQ: begin
        if (!level_ok || fill_count[s1_level] == '0) begin
          status_next = STAT_EMPTY;
        end else begin
          pop_en = 1'b1;
        end
      end
      KIND_DEQ_FIRST: begin
        pop_level = first_level;
        if (first_found) begin
          pop_en = 1'b1;
        end else begin
          status_next = STAT_EMPTY;
        end
      end
      default: begin
        // no operation
      end
    endcase

    rd_addr = slot_addr(pop_level, head_index[pop_level]);
    if (pop_en) begin
      removed_next = 1'b1;
      head_index_next[pop_level] = ring_next(head_index[pop_level]);
      fill_count_next[pop_level] = fill_count[pop_level] - CNT_W'(1);
    end
    level_next = pop_en ? pop_level : '0;

    all_empty_next = 1'b1;
    for (int q = 0; q < LEVELS; q++) begin
      if (fill_count_next[q] != '0) begin
        all_empty_next = 1'b0;
      end
    end
  end

  // Control and queue state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int q = 0; q < LEVELS; q++) begin
        head_index[q] <= '0;
        tail_index[q] <= '0;
        fill_count[q] <= '0;
      end
    end else begin
      if (advance) begin
        s1_valid  <= in_valid;
        out_valid <= s1_valid;
        if (s1_valid) begin
          for (int q = 0; q < LEVELS; q++) begin
            head_index[q] <= head_index_next[q];
            tail_index[q] <= tail_index_next[q];
            fill_count[q] <= fill_count_next[q];
          end
        end
      end
    end
  end

  // Payload registers and entry store
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_kind  <= kind;
      s1_level <= level;
      s1_pid   <= process_id;
      s1_time  <= time_value;
      if (s1_valid && do_write) begin
        entry_store[wr_addr] <= {s1_pid, s1_time};
      end
      rd_data       <= entry_store[rd_addr];
      removed       <= removed_next;
      status_reg    <= status_next;
      level_reg     <= level_next;
      all_empty_reg <= all_empty_next;
    end
  end

  // Drop the read data when nothing was removed
  assign status         = status_reg;
  assign out_process_id = removed ? rd_data[ENTRY_W-1 -: PID_W] : '0;
  assign out_time_value = removed ? signed'(rd_data[TIME_W-1:0]) : '0;
  assign out_level      = level_reg;
  assign all_empty      = all_empty_reg;

  // Consistency of the ring pointers and fill counts
  logic counts_ok;
  logic rings_ok;
  always_comb begin
    logic [PTR_W:0] sum;
    counts_ok = 1'b1;
    rings_ok  = 1'b1;
    for (int q = 0; q < LEVELS; q++) begin
      if (int'(fill_count[q]) > QUEUE_DEPTH) begin
        counts_ok = 1'b0;
      end
      sum = (PTR_W + 1)'(int'(head_index[q]) + int'(fill_count[q]));
      if (int'(sum) >= QUEUE_DEPTH) begin
        sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
      end
      if (sum[PTR_W-1:0] != tail_index[q]) begin
        rings_ok = 1'b0;
      end
    end
  end

  `MRQ_ASSERT(a_fill_bound, counts_ok, "fill count above queue depth")
  `MRQ_ASSERT(a_ring_consistent, rings_ok, "tail differs from head plus fill count")
  `MRQ_ASSERT(a_removed_ok, out_valid && removed |-> status == STAT_OK,
              "entry removed with a non-ok status")
  `MRQ_ASSERT_ALWAYS(a_stall_held, in_stall |-> out_valid && out_stall,
                     "input stalled with no result beat held")

endmodule

>>> sim/mrq_checker.sv
// Scoreboard for the multilevel ready queue: predicts every result beat and compares it.
module mrq_checker
  import mrq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [LEVEL_W-1:0]       level,
  input  logic [PID_W-1:0]         process_id,
  input  logic signed [TIME_W-1:0] time_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [STATUS_W-1:0]      status,
  input  logic [PID_W-1:0]         out_process_id,
  input  logic signed [TIME_W-1:0] out_time_value,
  input  logic [LEVEL_W-1:0]       out_level,
  input  logic                     all_empty,
  output int                       fail_count,
  output int                       pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [PID_W-1:0]        pid;
    logic signed [TIME_W-1:0] tv;
    logic [LEVEL_W-1:0]      lvl;
    logic                    all_empty;
  } queue_result_t;

  logic [PID_W-1:0]  pid_mem  [LEVELS*QUEUE_DEPTH];
  logic [TIME_W-1:0] time_mem [LEVELS*QUEUE_DEPTH];
  int                head_ptr  [LEVELS];
  int                tail_ptr  [LEVELS];
  int                occupancy [LEVELS];

  queue_result_t     due_results [$];
  int                mismatches = 0;

  // Remove the head of a non-empty level into the result.
  function automatic void take_head(input int q, inout queue_result_t r);
    int slot;
    slot = q * QUEUE_DEPTH + head_ptr[q];
    r.pid = pid_mem[slot];
    r.tv  = time_mem[slot];
    r.lvl = LEVEL_W'(q);
    head_ptr[q] = (head_ptr[q] + 1) % QUEUE_DEPTH;
    occupancy[q]--;
  endfunction

  function automatic queue_result_t ready_queue_step(input logic [KIND_W-1:0]  k,
                                                     input logic [LEVEL_W-1:0] lv,
                                                     input logic [PID_W-1:0]   pid,
                                                     input logic [TIME_W-1:0]  tv);
    queue_result_t r;
    int q;
    int slot;
    r = '0;
    q = int'(lv);
    case (k)
      KIND_ENQ: begin
        if (q >= LEVELS || occupancy[q] >= QUEUE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          slot = q * QUEUE_DEPTH + tail_ptr[q];
          pid_mem[slot]  = pid;
          time_mem[slot] = tv;
          tail_ptr[q] = (tail_ptr[q] + 1) % QUEUE_DEPTH;
          occupancy[q]++;
        end
      end
      KIND_DEQ: begin
        if (q >= LEVELS || occupancy[q] == 0) r.status = STAT_EMPTY;
        else take_head(q, r);
      end
      KIND_DEQ_FIRST: begin
        r.status = STAT_EMPTY;
        for (int i = 0; i < LEVELS; i++) begin
          if (r.status == STAT_EMPTY && occupancy[i] != 0) begin
            take_head(i, r);
            r.status = STAT_OK;
          end
        end
      end
      default: ;
    endcase
    r.all_empty = 1'b1;
    for (int i = 0; i < LEVELS; i++) begin
      if (occupancy[i] != 0) r.all_empty = 1'b0;
    end
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input queue_result_t want,
                                        input queue_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%s: expected status %0d pid %0d time %0d level %0d all_empty %0d",
               what, want.status, want.pid, want.tv, want.lvl, want.all_empty);
      $display("%s: actual   status %0d pid %0d time %0d level %0d all_empty %0d",
               what, got.status, got.pid, got.tv, got.lvl, got.all_empty);
    end
  endfunction

  always @(posedge clk) begin : watch
    queue_result_t want;
    queue_result_t got;
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_ptr[i]  = 0;
        tail_ptr[i]  = 0;
        occupancy[i] = 0;
      end
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status, out_process_id, out_time_value, out_level, all_empty};
        if (due_results.size() == 0) begin
          note_mismatch("unexpected result beat", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(ready_queue_step(kind, level, process_id, time_value));
      end
    end
    fail_count <= mismatches;
    pending    <= due_results.size();
  end

endmodule

>>> sim/tb.sv
// Testbench top for the multilevel ready queue: stimulus, handshake pacing and verdict.
module tb;
  import mrq_pkg::*;

  // Kind 3 has no name in the package: the block treats it as a no-op.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 4;
  localparam int BLOCK_ITEMS  = 50;    // items sharing one enqueue bias
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 5000;  // cycles with no beat before giving up
  localparam int TAIL_CYCLES  = 20;    // settle time after the last result

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        kind       = '0;
  logic [LEVEL_W-1:0]       level      = '0;
  logic [PID_W-1:0]         process_id = '0;
  logic signed [TIME_W-1:0] time_value = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic [STATUS_W-1:0]      status;
  logic [PID_W-1:0]         out_process_id;
  logic signed [TIME_W-1:0] out_time_value;
  logic [LEVEL_W-1:0]       out_level;
  logic                     all_empty;

  int fail_count;
  int pending;

  // Pacing: sender idle and receiver stall percentages for each phase.
  int phase_idle  [PHASES] = '{0, 67, 0, 22};
  int phase_stall [PHASES] = '{0, 0, 67, 22};
  int idle_pct  = 0;
  int stall_pct = 0;

  // Long hold-off handshake between the stimulus and the receiver process.
  bit hold_go   = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int quiet_cycles = 0;

  multilevel_ready_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .level          (level),
    .process_id     (process_id),
    .time_value     (time_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_process_id (out_process_id),
    .out_time_value (out_time_value),
    .out_level      (out_level),
    .all_empty      (all_empty)
  );

  mrq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .level          (level),
    .process_id     (process_id),
    .time_value     (time_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_process_id (out_process_id),
    .out_time_value (out_time_value),
    .out_level      (out_level),
    .all_empty      (all_empty),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: a toggle of hold_go starts a long hold-off counted here; otherwise
  // stall at random at the current phase's rate.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: give up once no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("multilevel_ready_queue regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat, idling first at the phase's rate, and hold it until taken.
  // Valid is only lowered inside the idle loop, so it never drops and rises
  // again within one step between back-to-back beats.
  task automatic send_beat(input logic [KIND_W-1:0]        k,
                           input logic [LEVEL_W-1:0]       lv,
                           input logic [PID_W-1:0]         pid,
                           input logic signed [TIME_W-1:0] tv);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    level      <= lv;
    process_id <= pid;
    time_value <= tv;
    do @(posedge clk); while (in_stall);
  endtask

  // Pause the sender until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int                       pick;
    int                       enq_pct;
    int                       focus;
    logic [KIND_W-1:0]        k;
    logic [LEVEL_W-1:0]       lv;
    logic signed [TIME_W-1:0] tv;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every kind, empty and full levels.
    send_beat(KIND_ENQ, 2'd0, 16'h0000, -16'sd1);
    send_beat(KIND_ENQ, 2'd3, 16'hffff, 16'sh7fff);
    send_beat(KIND_NOP, 2'd2, 16'h1234, 16'sh8000);
    send_beat(KIND_DEQ, 2'd1, 16'h0000, 16'sd0);        // empty level
    send_beat(KIND_DEQ_FIRST, 2'd3, 16'h0000, 16'sd0);  // takes level 0
    send_beat(KIND_DEQ, 2'd3, 16'h0000, 16'sd0);        // empties everything
    send_beat(KIND_DEQ_FIRST, 2'd0, 16'h0000, 16'sd0);  // nothing anywhere
    send_beat(KIND_DEQ, 2'd2, 16'h0000, 16'sd0);
    // Fill level 2 and push one more to hit the full case.
    for (int i = 0; i <= QUEUE_DEPTH; i++) begin
      send_beat(KIND_ENQ, 2'd2, PID_W'(16'ha5a0 + i), TIME_W'(i));
    end
    wait_drained();

    // Random: blocks with a varying enqueue bias and sometimes one hot level,
    // so levels run both full and dry.
    for (int p = 0; p < PHASES; p++) begin
      idle_pct = phase_idle[p];
      stall_pct <= phase_stall[p];
      enq_pct = 50;
      focus = LEVELS;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % BLOCK_ITEMS == 0) begin
          case ($urandom_range(2))
            0:       enq_pct = 25;
            1:       enq_pct = 50;
            default: enq_pct = 75;
          endcase
          focus = $urandom_range(LEVELS);
        end
        // Back the output up for a long stretch while beats keep coming.
        if (p == 0 && n == 100) hold_go <= ~hold_go;
        pick = $urandom_range(99);
        if (pick < enq_pct) k = KIND_ENQ;
        else if (pick < 96) k = $urandom_range(1) ? KIND_DEQ : KIND_DEQ_FIRST;
        else k = KIND_NOP;
        if (focus < LEVELS && $urandom_range(1) == 1) lv = LEVEL_W'(focus);
        else lv = LEVEL_W'($urandom_range(LEVELS - 1));
        case ($urandom_range(7))
          0:       tv = -16'sd1;
          1:       tv = 16'sh7fff;
          2:       tv = 16'sd0;
          default: tv = TIME_W'($urandom);
        endcase
        send_beat(k, lv, PID_W'($urandom), tv);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("multilevel_ready_queue regression: pass");
    end else begin
      $display("multilevel_ready_queue regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mrq_pkg.sv
rtl/core/multilevel_ready_queue.sv
sim/mrq_checker.sv
sim/tb.sv
